// ----- rtl/rpmfi_pkg.sv -----
// Package for the rpm to motor frequency interpolator.
// Holds sizes, calibration tables, table lookup functions and the
// controller/datapath command and status types. No dependencies.
package rpmfi_pkg;

    localparam int N_POINTS      = 24;
    localparam int RPM_FRAC_BITS = 10;
    localparam int CAL_POINTS    = 24;
    localparam int CAL_FRAC_BITS = 10;

    localparam int SPD_W  = 20;
    localparam int RPM_W  = 19;
    localparam int FREQ_W = 31;
    localparam int IDX_W  = $clog2(2 * N_POINTS);
    localparam int KC_W   = $clog2(CAL_POINTS);

    localparam int RPM_MAX  = 524287;
    localparam int SHIFT_W  = RPM_W + 16;

    localparam logic [30:0] FREQ_BASE = 31'd1196612456;
    localparam logic [30:0] FREQ_STEP = 31'd4063228;

    // Divider sizes: signed numerator, magnitude divided two bits a cycle
    localparam int PA_W      = FREQ_W + RPM_W;
    localparam int DS_W      = SPD_W + 1;
    localparam int DF_W      = FREQ_W + 1;
    localparam int PB_W      = DS_W + DF_W;
    localparam int NUM_W     = ((PB_W + 2) / 2) * 2;
    localparam int DIV_STEPS = NUM_W / 2;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [RPM_W-1:0] CAL_POS [CAL_POINTS] = '{
        19'd0, 19'd30, 19'd168, 19'd296, 19'd441, 19'd656, 19'd987, 19'd1495,
        19'd2723, 19'd5305, 19'd11719, 19'd13787, 19'd21458, 19'd28015,
        19'd36904, 19'd46641, 19'd60413, 19'd80599, 19'd108391, 19'd144779,
        19'd192621, 19'd253325, 19'd325012, 19'd407332};

    localparam logic [RPM_W-1:0] CAL_NEG [CAL_POINTS] = '{
        19'd0, 19'd55, 19'd194, 19'd338, 19'd629, 19'd1121, 19'd2068, 19'd3299,
        19'd3863, 19'd6537, 19'd10891, 19'd15675, 19'd20716, 19'd27892,
        19'd36084, 19'd46421, 19'd59901, 19'd79376, 19'd105762, 19'd141482,
        19'd188329, 19'd248589, 19'd320341, 19'd401110};

    typedef struct packed {
        logic load;
        logic step;
        logic fetch;
        logic mul;
        logic sum;
        logic div;
        logic out_load;
    } t_ctl_cmd;

    typedef struct packed {
        logic found;
        logic flat;
        logic div_last;
        logic out_free;
    } t_ctl_sts;

    // Calibration row of a table index; rows past the data repeat the last one
    function automatic logic [KC_W-1:0] cal_row(input logic [IDX_W-1:0] idx);
        logic [IDX_W-1:0] k;
        k = (int'(idx) >= N_POINTS) ? idx - IDX_W'(N_POINTS) : idx;
        if (int'(k) > CAL_POINTS - 1) begin
            return KC_W'(CAL_POINTS - 1);
        end
        return KC_W'(k);
    endfunction

    function automatic logic [RPM_W-1:0] rpm_point(input logic [IDX_W-1:0] idx);
        logic [KC_W-1:0]    kc;
        logic [RPM_W-1:0]   v;
        logic [SHIFT_W-1:0] w;
        kc = cal_row(idx);
        v  = (int'(idx) >= N_POINTS) ? CAL_NEG[kc] : CAL_POS[kc];
        w  = SHIFT_W'(v);
        if (RPM_FRAC_BITS >= CAL_FRAC_BITS) begin
            w = w << (RPM_FRAC_BITS - CAL_FRAC_BITS);
        end else begin
            w = w >> (CAL_FRAC_BITS - RPM_FRAC_BITS);
        end
        if (w > SHIFT_W'(RPM_MAX)) begin
            w = SHIFT_W'(RPM_MAX);
        end
        return w[RPM_W-1:0];
    endfunction

    function automatic logic [FREQ_W-1:0] freq_point(input logic [IDX_W-1:0] idx);
        logic [31:0] t;
        t = 32'(FREQ_BASE) - 32'(FREQ_STEP) * 32'(cal_row(idx));
        return t[FREQ_W-1:0];
    endfunction

endpackage

// ----- rtl/rpmfi_if.sv -----
// Channel interfaces of the rpm to motor frequency interpolator.
// Depends on rpmfi_pkg for field widths.
interface rpmfi_in_if import rpmfi_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SPD_W-1:0] desired_rpm;

    modport source (output valid, output desired_rpm, input ready);
    modport sink   (input valid, input desired_rpm, output ready);
endinterface

interface rpmfi_out_if import rpmfi_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FREQ_W-1:0] motor_freq_word;
    logic              clamped;

    modport source (output valid, output motor_freq_word, output clamped, input ready);
    modport sink   (input valid, input motor_freq_word, input clamped, output ready);
endinterface

// ----- rtl/rpmfi_ctrl.sv -----
// Sequencing state machine of the interpolator: search, multiply, sum,
// divide, deliver. Depends on rpmfi_pkg for command and status types.
module rpmfi_ctrl import rpmfi_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_ctl_sts i_sts,
    output t_ctl_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_MUL,
        S_SUM,
        S_DIV,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (i_sts.found) begin
                    o_cmd.fetch = 1'b1;
                    n_state     = S_MUL;
                end else begin
                    o_cmd.step = 1'b1;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = i_sts.flat ? S_FIN : S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_accept_starts_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_SEARCH))
        else $error("accepted beat did not start a search");

    a_search_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH && !i_sts.found) |=> (r_state == S_SEARCH))
        else $error("search left before a breakpoint was found");

    a_div_ends_in_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_sts.div_last) |=> (r_state == S_FIN))
        else $error("divider finished without moving to delivery");

endmodule

// ----- rtl/rpmfi_dpath.sv -----
// Datapath of the interpolator: breakpoint search index, segment fetch,
// two multipliers, numerator sum, radix-4 restoring divider, output register.
// Depends on rpmfi_pkg for tables, sizes and command/status types.
module rpmfi_dpath import rpmfi_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ctl_cmd                i_cmd,
    output t_ctl_sts                o_sts,
    input  logic signed [SPD_W-1:0] i_desired_rpm,
    input  logic                    i_out_ready,
    output logic                    o_out_valid,
    output logic [FREQ_W-1:0]       o_motor_freq_word,
    output logic                    o_clamped
);

    logic [SPD_W-1:0]        r_mag;
    logic                    r_neg_tbl;
    logic [IDX_W-1:0]        r_idx;
    logic [FREQ_W-1:0]       r_f0;
    logic signed [DF_W-1:0]  r_df;
    logic signed [DS_W-1:0]  r_ds;
    logic signed [SPD_W-1:0] r_den;
    logic [PA_W-1:0]         r_pa;
    logic signed [PB_W-1:0]  r_pb;
    logic                    r_flat;
    logic                    r_qneg;
    logic [NUM_W-1:0]        r_dq;
    logic [RPM_W-1:0]        r_rem;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_out_valid;
    logic [FREQ_W-1:0]       r_out_freq;
    logic                    r_out_clamp;

    logic [IDX_W-1:0]        tbl_base;
    logic [IDX_W-1:0]        seg_idx;
    logic [IDX_W-1:0]        idx1;
    logic [IDX_W-1:0]        idx0;
    logic [RPM_W-1:0]        r0;
    logic [RPM_W-1:0]        r1;
    logic [FREQ_W-1:0]       f0;
    logic [FREQ_W-1:0]       f1;
    logic signed [NUM_W-1:0] num;
    logic [RPM_W-1:0]        d;
    logic [RPM_W:0]          t1;
    logic [RPM_W:0]          t2;
    logic                    ge1;
    logic                    ge2;
    logic [RPM_W-1:0]        rem1;
    logic [RPM_W-1:0]        rem2;
    logic [NUM_W-1:0]        dq1;
    logic [NUM_W-1:0]        dq2;
    logic [FREQ_W-1:0]       res_freq;
    logic                    res_clamp;

    assign tbl_base = r_neg_tbl ? IDX_W'(N_POINTS) : '0;
    assign seg_idx  = (r_idx == '0) ? IDX_W'(1) : r_idx;
    assign idx1     = tbl_base + seg_idx;
    assign idx0     = idx1 - IDX_W'(1);
    assign r0       = rpm_point(idx0);
    assign r1       = rpm_point(idx1);
    assign f0       = freq_point(idx0);
    assign f1       = freq_point(idx1);

    assign o_sts.found = (r_idx == IDX_W'(N_POINTS - 1))
                      || ({1'b0, rpm_point(tbl_base + r_idx)} >= r_mag);
    assign o_sts.flat     = r_flat;
    assign o_sts.div_last = (r_cnt == CNT_W'(DIV_STEPS - 1));
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign num = NUM_W'($signed({1'b0, r_pa})) + NUM_W'(r_pb);

    // Two restoring quotient bits a cycle
    assign d    = r_den[RPM_W-1:0];
    assign t1   = {r_rem, r_dq[NUM_W-1]};
    assign ge1  = t1 >= {1'b0, d};
    assign rem1 = ge1 ? RPM_W'(t1 - {1'b0, d}) : t1[RPM_W-1:0];
    assign dq1  = {r_dq[NUM_W-2:0], ge1};
    assign t2   = {rem1, dq1[NUM_W-1]};
    assign ge2  = t2 >= {1'b0, d};
    assign rem2 = ge2 ? RPM_W'(t2 - {1'b0, d}) : t2[RPM_W-1:0];
    assign dq2  = {dq1[NUM_W-2:0], ge2};

    always_comb begin
        res_freq  = r_dq[FREQ_W-1:0];
        res_clamp = 1'b0;
        if (r_flat) begin
            res_freq = r_f0;
        end else if (r_qneg && r_dq != '0) begin
            res_freq  = '0;
            res_clamp = 1'b1;
        end else if (r_dq > NUM_W'({FREQ_W{1'b1}})) begin
            res_freq  = '1;
            res_clamp = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_neg_tbl <= (i_desired_rpm <= 0);
            r_mag     <= (i_desired_rpm <= 0) ? SPD_W'(-i_desired_rpm)
                                              : SPD_W'(i_desired_rpm);
            r_idx     <= '0;
        end else if (i_cmd.step) begin
            r_idx <= r_idx + IDX_W'(1);
        end
        if (i_cmd.fetch) begin
            r_f0  <= f0;
            r_df  <= $signed({1'b0, f1}) - $signed({1'b0, f0});
            r_ds  <= $signed({1'b0, r_mag}) - $signed(DS_W'(r0));
            r_den <= $signed({1'b0, r1}) - $signed({1'b0, r0});
        end
        if (i_cmd.mul) begin
            r_pa   <= PA_W'(r_f0) * PA_W'(r_den[RPM_W-1:0]);
            r_pb   <= PB_W'(r_ds) * PB_W'(r_df);
            r_flat <= r_den[SPD_W-1] || (r_den == '0);
        end
        if (i_cmd.sum) begin
            r_qneg <= num[NUM_W-1];
            r_dq   <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            r_rem  <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.div) begin
            r_dq  <= dq2;
            r_rem <= rem2;
            r_cnt <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.out_load) begin
            r_out_freq  <= res_freq;
            r_out_clamp <= res_clamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_motor_freq_word = r_out_freq;
    assign o_clamped         = r_out_clamp;

    a_div_not_flat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div |-> !r_flat)
        else $error("divider ran on a flat segment");

    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> (r_idx < IDX_W'(N_POINTS - 1)))
        else $error("search stepped past the last breakpoint");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result overwrote an unread beat");

endmodule

// ----- rtl/rpm_to_motor_frequency_interp.sv -----
// Latency runs from the accepted input beat to the first edge that can take the result;
//   it grows with k (0..23), the number of breakpoints the serial search passes, and a
//   flat segment skips the divider.
// Throughput: one beat at a time; the next input is taken once the previous
//   result sits in the output register, so with a ready receiver the period equals the latency.
// Reset (synchronous, active low) returns the sequencer to idle and empties the
//   output register; calibration tables are constant and need no clearing.
module rpm_to_motor_frequency_interp import rpmfi_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    rpmfi_in_if.sink     i_cmd,
    rpmfi_out_if.source  o_res
);

    // Command and status between the sequencer and the datapath
    t_ctl_cmd cmd;
    t_ctl_sts sts;

    // Sequencer: owns input ready and steps the datapath through the
    // search, multiply, sum, divide and delivery phases.
    rpmfi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_cmd.valid),
        .o_in_ready (i_cmd.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath: holds the speed magnitude, segment operands, products,
    // divider and the output register that decouples the result side.
    rpmfi_dpath u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_desired_rpm     (i_cmd.desired_rpm),
        .i_out_ready       (o_res.ready),
        .o_out_valid       (o_res.valid),
        .o_motor_freq_word (o_res.motor_freq_word),
        .o_clamped         (o_res.clamped)
    );

endmodule
